@@ rtl/shs_pkg.sv @@
// ----------------------------------------------------------------------------
// shs_pkg: shared types, constants and functions of the sha-256 hasher
// Holds the round constants, the initial hash values, the sigma functions
// and the control and status structs between the top level and the core.
// ----------------------------------------------------------------------------
package shs_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned NumHash = 8;
	localparam int unsigned BlkW    = 512;
	localparam int unsigned Rounds  = 64;
	localparam int unsigned RndW    = 6;
	localparam int unsigned CntW    = 6;
	localparam int unsigned LenW    = 64;

	localparam logic [7:0] PadByte  = 8'h80;
	localparam logic [CntW-1:0] LenStart = 6'd56;

	typedef logic [WordW-1:0] word_t;
	typedef word_t [NumHash-1:0] hash_t;

	// commands from the top level to the compression core
	typedef struct packed {
		logic start;
		logic reinit;
	} core_ctl_t;

	// status from the compression core
	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	localparam hash_t InitHash = '{
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t ror(input word_t v, input int unsigned n);
		ror = (v >> n) | (v << (WordW - n));
	endfunction

	function automatic word_t big_sig0(input word_t a);
		big_sig0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
	endfunction

	function automatic word_t big_sig1(input word_t e);
		big_sig1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
	endfunction

	function automatic word_t sml_sig0(input word_t x);
		sml_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sml_sig1(input word_t y);
		sml_sig1 = ror(y, 17) ^ ror(y, 19) ^ (y >> 10);
	endfunction

	// round constant table
	function automatic word_t round_k(input logic [RndW-1:0] t);
		word_t k;
		case (t)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = '0;
		endcase
		round_k = k;
	endfunction

endpackage

@@ rtl/sha256_stream_hasher_unit.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit: byte-stream sha-256 hasher
// Absorbs one message byte per item; a finish item pads and emits the digest.
// ----------------------------------------------------------------------------
// An absorb item only shifts its byte in, except the one that fills the 64-byte
// block: it starts the compression core, which runs one round per cycle, and the
// unit stays busy until the core is done. A finish item shifts in the padding one
// byte per cycle (64 minus pending bytes) and compresses; with 56 or more
// bytes pending a second pass shifts in a full 64 padding bytes and compresses
// again. The digest is then written into the output register once that
// register is free.
module sha256_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  msg_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_part_0,
	output logic [63:0] digest_part_1,
	output logic [63:0] digest_part_2,
	output logic [63:0] digest_part_3
);
	import shs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PAD  = 4'b0010,
		ST_CMP  = 4'b0100,
		ST_OUT  = 4'b1000
	} st_t;

	st_t               st_q;
	logic [CntW-1:0]   cnt_q;
	logic [LenW-1:0]   bits_q;
	logic [LenW-1:0]   len_q;
	logic              fin_q;
	logic              last_q;
	logic              first_q;
	logic [BlkW-1:0]   blk_q;
	logic              out_valid_q;
	logic [63:0]       dig0_q, dig1_q, dig2_q, dig3_q;

	logic              in_acc;
	logic              shift_en;
	logic [7:0]        byte_in;
	logic [7:0]        pad_byte;
	logic [BlkW-1:0]   blk_d;
	core_ctl_t         cctl;
	core_sts_t         csts;
	hash_t             hash;

	assign in_ready = (st_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// padding byte: marker, zeros, then length big-endian in the last block
	always_comb begin
		if (first_q) begin
			pad_byte = PadByte;
		end else if (last_q && cnt_q >= LenStart) begin
			pad_byte = len_q[{~cnt_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = '0;
		end
	end

	assign shift_en = (in_acc && !func) || (st_q == ST_PAD);
	assign byte_in  = (st_q == ST_PAD) ? pad_byte : msg_byte;
	assign blk_d    = {blk_q[BlkW-9:0], byte_in};

	assign cctl.start  = shift_en && (cnt_q == '1);
	assign cctl.reinit = (st_q == ST_OUT) && !out_valid_q;

	shs_compress u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.blk    (blk_d),
		.sts    (csts),
		.hash   (hash)
	);

	// block buffer shift register
	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= blk_d;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			bits_q      <= '0;
			fin_q       <= 1'b0;
			last_q      <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_acc && !func) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == '1) begin
							bits_q <= bits_q + LenW'(BlkW);
							st_q   <= ST_CMP;
						end
					end else if (in_acc) begin
						fin_q   <= 1'b1;
						first_q <= 1'b1;
						last_q  <= (cnt_q < LenStart);
						st_q    <= ST_PAD;
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						st_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (csts.done) begin
						if (!fin_q) begin
							st_q <= ST_IDLE;
						end else if (last_q) begin
							st_q <= ST_OUT;
						end else begin
							last_q <= 1'b1;
							st_q   <= ST_PAD;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						bits_q      <= '0;
						fin_q       <= 1'b0;
						last_q      <= 1'b0;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// message length latched at finish
	always_ff @(posedge clk) begin
		if (in_acc && func) begin
			len_q <= bits_q + LenW'({cnt_q, 3'b000});
		end
	end

	// digest output register
	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && !out_valid_q) begin
			dig0_q <= {hash[0], hash[1]};
			dig1_q <= {hash[2], hash[3]};
			dig2_q <= {hash[4], hash[5]};
			dig3_q <= {hash[6], hash[7]};
		end
	end

	assign out_valid     = out_valid_q;
	assign digest_part_0 = dig0_q;
	assign digest_part_1 = dig1_q;
	assign digest_part_2 = dig2_q;
	assign digest_part_3 = dig3_q;

`ifndef SYNTH
	// core finishes only while the sequencer waits for it
	a_done_in_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		csts.done |-> st_q == ST_CMP)
		else $error("core done outside compress wait");

	// a new block is never started on a busy core
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cctl.start |-> !csts.busy)
		else $error("core started while busy");

	// a digest appears only from the output state
	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q == ST_OUT))
		else $error("digest issued outside output state");
`endif

endmodule

@@ rtl/shs_compress.sv @@
// ----------------------------------------------------------------------------
// shs_compress: iterative sha-256 compression core
// Runs one round per cycle over a 16-word rolling schedule window, then adds
// the working variables into the chaining hash in a separate add state.
// ----------------------------------------------------------------------------
module shs_compress (
	input  logic                        clk,
	input  logic                        arst_n,
	input  shs_pkg::core_ctl_t          ctl,
	input  logic [shs_pkg::BlkW-1:0]    blk,
	output shs_pkg::core_sts_t          sts,
	output shs_pkg::hash_t              hash
);
	import shs_pkg::*;

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_ADD  = 3'b100
	} cst_t;

	cst_t              cst_q;
	logic [RndW-1:0]   rnd_q;
	logic [BlkW-1:0]   win_q;
	hash_t             hash_q;
	hash_t             v_q;

	word_t w0, w1, w9, w14, w_new;
	word_t t1, t2;

	// schedule window taps, word 0 in the top bits
	assign w0  = win_q[BlkW-1 -: WordW];
	assign w1  = win_q[BlkW-1-WordW -: WordW];
	assign w9  = win_q[BlkW-1-9*WordW -: WordW];
	assign w14 = win_q[BlkW-1-14*WordW -: WordW];
	assign w_new = sml_sig1(w14) + w9 + sml_sig0(w1) + w0;

	// round function
	assign t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ round_k(rnd_q) + w0;
	assign t2 = big_sig0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q  <= C_IDLE;
			rnd_q  <= '0;
			hash_q <= InitHash;
		end else begin
			case (cst_q)
				C_IDLE: begin
					if (ctl.start) begin
						cst_q <= C_RUN;
						rnd_q <= '0;
					end else if (ctl.reinit) begin
						hash_q <= InitHash;
					end
				end
				C_RUN: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RndW'(Rounds - 1)) begin
						cst_q <= C_ADD;
					end
				end
				C_ADD: begin
					for (int i = 0; i < NumHash; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					cst_q <= C_IDLE;
				end
				default: cst_q <= C_IDLE;
			endcase
		end
	end

	// datapath: window and working variables
	always_ff @(posedge clk) begin
		if (cst_q == C_IDLE && ctl.start) begin
			win_q <= blk;
			v_q   <= hash_q;
		end else if (cst_q == C_RUN) begin
			win_q <= {win_q[BlkW-WordW-1:0], w_new};
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign sts.busy = (cst_q != C_IDLE);
	assign sts.done = (cst_q == C_ADD);
	assign hash     = hash_q;

endmodule
